/* rtl/core/fst_pkg.sv */
package fst_pkg;

   localparam int ENTRIES   = 64;
   localparam int KEY_BYTES = 8;
   localparam int SLOT_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W     = $clog2(ENTRIES + 1);
   localparam int BYTE_W    = $clog2(KEY_BYTES + 1);

   typedef enum logic [1:0] {
      MODE_INSERT = 2'd0,
      MODE_UPDATE = 2'd1,
      MODE_REMOVE = 2'd2,
      MODE_LOOKUP = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_DONE      = 2'd0,
      STATUS_PRESENT   = 2'd1,
      STATUS_NOT_FOUND = 2'd2,
      STATUS_FULL      = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_HASH,
      ST_SCAN,
      ST_WRITE
   } state_type;

   typedef struct packed {
      logic [7:0]  fp;
      logic [3:0]  len;
      logic [63:0] key;
      logic [63:0] value;
   } entry_type;

   typedef struct packed {
      logic              we;
      logic [SLOT_W-1:0] waddr;
      entry_type         wdata;
      logic [SLOT_W-1:0] raddr;
   } mem_req_type;

   // one step of the fingerprint: rotate left 5 within 32 bits, then xor the byte
   function automatic logic [31:0] fp_step(input logic [31:0] h, input logic [7:0] b);
      fp_step = {h[26:0], h[31:27]} ^ {24'd0, b};
   endfunction

endpackage

/* rtl/core/fst_store.sv */
module fst_store (
   input  logic                 clock,
   input  fst_pkg::mem_req_type mem_req,
   output fst_pkg::entry_type   rd_entry
);

   fst_pkg::entry_type mem [fst_pkg::ENTRIES];
   fst_pkg::entry_type rd_entry_ff;

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem[mem_req.waddr] <= mem_req.wdata;
      end
      rd_entry_ff <= mem[mem_req.raddr];
   end

   assign rd_entry = rd_entry_ff;

endmodule

/* rtl/core/fingerprint_slot_table.sv */
// fingerprinted slot table: one node of ENTRIES slots holding key, length,
// fingerprint and value, with insert, update, remove and lookup requests
// req channel: one request item per handshake; req_tready is high only while
// the sequencer is idle, so one request is worked on at a time
// rsp channel: exactly one result item per request, held in an output
// register until taken
// per request: the request is taken while idle, the hash state runs each key
// byte through the shared fingerprint step, the scan state sweeps the slot
// memory one read a cycle (the single read port sets the sweep length), and
// the write state decides and writes back; the result then sits in the
// output register and the sequencer returns to idle, so the next request is
// taken only once this one is finished.
// a finished result may wait in the output register while the next request
// is accepted; if the receiver stalls longer, the decide step holds until
// the output register is free, and nothing is lost
// reset empties the node at once (all occupied bits and the count cleared);
// slot contents are not cleared and are only read behind an occupied bit
module fingerprint_slot_table (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // mode[1:0], key_bytes[65:2], key_length[69:66], new_value[133:70], zero pad
   input  logic [135:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status[1:0], found_value[65:2], slot[71:66], entry_count[78:72], zero pad
   output logic [79:0]  rsp_tdata
);

   localparam int SW = fst_pkg::SLOT_W;
   localparam int CW = fst_pkg::CNT_W;
   localparam int BW = fst_pkg::BYTE_W;

   fst_pkg::state_type state_ff, state_in;

   logic [fst_pkg::ENTRIES-1:0] occ_ff, occ_in;
   logic [CW-1:0]               count_ff, count_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [79:0]                 rsp_data_ff, rsp_data_in;

   // request payload
   fst_pkg::mode_type mode_ff;
   logic [63:0]       key_ff;
   logic [3:0]        len_ff;
   logic [63:0]       val_ff;
   logic [31:0]       hash_ff, hash_in;
   logic [BW-1:0]     byte_ff, byte_in;

   // scan bookkeeping
   logic [CW-1:0] scan_ff, scan_in;
   logic [SW-1:0] eval_idx_ff;
   logic          eval_occ_ff;
   logic          match_ff, match_in;
   logic [SW-1:0] match_idx_ff, match_idx_in;
   logic [63:0]   match_val_ff, match_val_in;
   logic          free_ff, free_in;
   logic [SW-1:0] free_idx_ff, free_idx_in;

   fst_pkg::mem_req_type mem_req;
   fst_pkg::entry_type   rd_entry;

   logic [3:0]  req_len_raw, req_len_sat;
   logic [63:0] req_key_raw, req_key_mask;
   logic        accept;
   logic        out_free;
   logic        hit;

   fst_store u_store (
      .clock    (clock),
      .mem_req  (mem_req),
      .rd_entry (rd_entry)
   );

   assign req_len_raw = req_tdata[69:66];
   assign req_key_raw = req_tdata[65:2];
   assign req_len_sat = (req_len_raw > 4'(fst_pkg::KEY_BYTES)) ?
                        4'(fst_pkg::KEY_BYTES) : req_len_raw;

   // bytes past the valid length are stored as zero
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         req_key_mask[8*i +: 8] = (4'(i) < req_len_sat) ? req_key_raw[8*i +: 8] : 8'd0;
      end
   end

   assign req_tready = (state_ff == fst_pkg::ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign hit = eval_occ_ff && (rd_entry.fp == hash_ff[7:0]) &&
                (rd_entry.len == len_ff) && (rd_entry.key == key_ff);

   always_comb begin
      fst_pkg::status_type status;
      logic [63:0]         found;
      logic [SW-1:0]       slot;

      state_in     = state_ff;
      occ_in       = occ_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      hash_in      = hash_ff;
      byte_in      = byte_ff;
      scan_in      = scan_ff;
      match_in     = match_ff;
      match_idx_in = match_idx_ff;
      match_val_in = match_val_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      status       = fst_pkg::STATUS_DONE;
      found        = 64'd0;
      slot         = '0;

      mem_req.we    = 1'b0;
      mem_req.waddr = '0;
      mem_req.wdata = '{fp: hash_ff[7:0], len: len_ff, key: key_ff, value: val_ff};
      mem_req.raddr = scan_ff[SW-1:0];

      case (state_ff)
         fst_pkg::ST_IDLE: begin
            if (accept) begin
               hash_in  = {28'd0, req_len_sat};
               byte_in  = '0;
               scan_in  = '0;
               match_in = 1'b0;
               free_in  = 1'b0;
               state_in = fst_pkg::ST_HASH;
            end
         end
         fst_pkg::ST_HASH: begin
            if (4'(byte_ff) < len_ff) begin
               hash_in = fst_pkg::fp_step(hash_ff, 8'(key_ff >> {byte_ff, 3'b000}));
               byte_in = byte_ff + 1'b1;
            end else begin
               state_in = fst_pkg::ST_SCAN;
            end
         end
         fst_pkg::ST_SCAN: begin
            // read issued for scan_ff, data for the previous slot checked now
            if (scan_ff != '0) begin
               if (hit && !match_ff) begin
                  match_in     = 1'b1;
                  match_idx_in = eval_idx_ff;
                  match_val_in = rd_entry.value;
               end
               if (!eval_occ_ff && !free_ff) begin
                  free_in     = 1'b1;
                  free_idx_in = eval_idx_ff;
               end
            end
            if (scan_ff == CW'(fst_pkg::ENTRIES)) begin
               state_in = fst_pkg::ST_WRITE;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         fst_pkg::ST_WRITE: begin
            if (mode_ff == fst_pkg::MODE_INSERT) begin
               if (match_ff) begin
                  status = fst_pkg::STATUS_PRESENT;
               end else if (!free_ff) begin
                  status = fst_pkg::STATUS_FULL;
               end else begin
                  slot = free_idx_ff;
               end
            end else if (!match_ff) begin
               status = fst_pkg::STATUS_NOT_FOUND;
            end else begin
               slot = match_idx_ff;
               if (mode_ff == fst_pkg::MODE_LOOKUP) begin
                  found = match_val_ff;
               end
            end
            if (out_free) begin
               if (status == fst_pkg::STATUS_DONE) begin
                  case (mode_ff)
                     fst_pkg::MODE_INSERT: begin
                        mem_req.we    = 1'b1;
                        mem_req.waddr = free_idx_ff;
                        occ_in[free_idx_ff] = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                     fst_pkg::MODE_UPDATE: begin
                        mem_req.we    = 1'b1;
                        mem_req.waddr = match_idx_ff;
                     end
                     fst_pkg::MODE_REMOVE: begin
                        occ_in[match_idx_ff] = 1'b0;
                        if (count_ff != '0) begin
                           count_in = count_ff - 1'b1;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
               rsp_valid_in = 1'b1;
               rsp_data_in  = {1'b0, 7'(count_in), 6'(slot), found, status};
               state_in     = fst_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fst_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fst_pkg::ST_IDLE;
         occ_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         match_ff     <= 1'b0;
         free_ff      <= 1'b0;
         scan_ff      <= '0;
         byte_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         match_ff     <= match_in;
         free_ff      <= free_in;
         scan_ff      <= scan_in;
         byte_ff      <= byte_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff <= fst_pkg::mode_type'(req_tdata[1:0]);
         key_ff  <= req_key_mask;
         len_ff  <= req_len_sat;
         val_ff  <= req_tdata[133:70];
      end
      hash_ff      <= hash_in;
      rsp_data_ff  <= rsp_data_in;
      match_idx_ff <= match_idx_in;
      match_val_ff <= match_val_in;
      free_idx_ff  <= free_idx_in;
      eval_idx_ff  <= scan_ff[SW-1:0];
      eval_occ_ff  <= occ_ff[scan_ff[SW-1:0]];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

/* sim/tb_fingerprint_slot_table.sv */
module tb_fingerprint_slot_table;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      fst_pkg::status_type status;
      logic [63:0]         found_value;
      logic [5:0]          slot;
      logic [6:0]          entry_count;
   } table_result_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [135:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [79:0]  rsp_tdata;

   // shadow copy of the node
   bit          slot_used [fst_pkg::ENTRIES];
   logic [7:0]  slot_fp [fst_pkg::ENTRIES];
   logic [63:0] slot_key [fst_pkg::ENTRIES];
   logic [3:0]  slot_len [fst_pkg::ENTRIES];
   logic [63:0] slot_value [fst_pkg::ENTRIES];
   int          used_count = 0;

   table_result_type pending_results[$];
   int               failures = 0;
   bit               idle_on = 1'b1;
   int               rsp_stall = 0;

   fingerprint_slot_table dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("status: fail");
      $finish;
   end

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // works out the result of one request and applies it to the shadow node
   function automatic table_result_type apply_request(fst_pkg::mode_type mode,
                                                      logic [63:0] key,
                                                      logic [3:0] len,
                                                      logic [63:0] value);
      table_result_type r;
      int               eff;
      logic [31:0]      h;
      logic [7:0]       fp;
      int               hit;
      int               free_slot;
      r = '0;
      r.status = fst_pkg::STATUS_DONE;
      eff = (len > fst_pkg::KEY_BYTES) ? fst_pkg::KEY_BYTES : int'(len);
      if (eff < 8) key = key & ((64'd1 << (8 * eff)) - 64'd1);
      h = 32'(eff);
      for (int i = 0; i < eff; i++) h = {h[26:0], h[31:27]} ^ {24'd0, key[8*i +: 8]};
      fp = h[7:0];
      hit = -1;
      for (int i = 0; i < fst_pkg::ENTRIES; i++) begin
         if (hit < 0 && slot_used[i] && slot_fp[i] == fp && slot_len[i] == eff &&
             slot_key[i] == key)
            hit = i;
      end
      if (mode == fst_pkg::MODE_INSERT) begin
         if (hit >= 0) begin
            r.status = fst_pkg::STATUS_PRESENT;
         end else begin
            free_slot = -1;
            for (int i = 0; i < fst_pkg::ENTRIES; i++)
               if (free_slot < 0 && !slot_used[i]) free_slot = i;
            if (free_slot < 0) begin
               r.status = fst_pkg::STATUS_FULL;
            end else begin
               slot_used[free_slot] = 1'b1;
               slot_fp[free_slot] = fp;
               slot_key[free_slot] = key;
               slot_len[free_slot] = 4'(eff);
               slot_value[free_slot] = value;
               used_count++;
               r.slot = free_slot[5:0];
            end
         end
      end else if (hit < 0) begin
         r.status = fst_pkg::STATUS_NOT_FOUND;
      end else begin
         r.slot = hit[5:0];
         case (mode)
            fst_pkg::MODE_UPDATE: begin
               slot_value[hit] = value;
            end
            fst_pkg::MODE_REMOVE: begin
               slot_used[hit] = 1'b0;
               if (used_count > 0) used_count--;
            end
            default: begin
               r.found_value = slot_value[hit];
            end
         endcase
      end
      r.entry_count = used_count[6:0];
      return r;
   endfunction

   // appends one expected result item at the tail of the queue
   task automatic queue_result(table_result_type r);
      pending_results = {pending_results, r};
   endtask

   task automatic send_request(fst_pkg::mode_type mode, logic [63:0] key, logic [3:0] len,
                               logic [63:0] value);
      int gap;
      gap = idle_on ? $urandom_range(0, 6) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {2'b00, value, len, key, mode};
      do @(posedge clock); while (!req_tready);
      queue_result(apply_request(mode, key, len, value));
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // fills the bytes beyond the valid length with junk
   function automatic logic [63:0] add_stray(logic [63:0] key, logic [3:0] len);
      logic [63:0] mask;
      if (len >= 8) return key;
      mask = (64'd1 << (8 * len)) - 64'd1;
      return (key & mask) | (rand64() & ~mask);
   endfunction

   always @(posedge clock) begin
      table_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("result item with no request outstanding");
            failures++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata[1:0] != want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_tdata[1:0]);
               failures++;
            end
            if (rsp_tdata[65:2] != want.found_value) begin
               $error("found_value: expected %h, actual %h", want.found_value,
                      rsp_tdata[65:2]);
               failures++;
            end
            if (rsp_tdata[71:66] != want.slot) begin
               $error("slot: expected %0d, actual %0d", want.slot, rsp_tdata[71:66]);
               failures++;
            end
            if (rsp_tdata[78:72] != want.entry_count) begin
               $error("entry_count: expected %0d, actual %0d", want.entry_count,
                      rsp_tdata[78:72]);
               failures++;
            end
         end
         rsp_stall = idle_on ? $urandom_range(0, 6) : 0;
      end
   end

   initial begin
      wait (!reset);
      forever begin
         @(negedge clock);
         if (rsp_stall > 0) begin
            rsp_tready <= 1'b0;
            rsp_stall--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic test_basic_ops();
      logic [63:0] k;
      k = 64'h0123_4567_89ab_cdef;
      send_request(fst_pkg::MODE_INSERT, k, 4'd8, '1);
      send_request(fst_pkg::MODE_INSERT, k, 4'd8, 64'h5);
      send_request(fst_pkg::MODE_LOOKUP, k, 4'd8, rand64());
      send_request(fst_pkg::MODE_UPDATE, k, 4'd8, '0);
      send_request(fst_pkg::MODE_LOOKUP, k, 4'd8, '1);
      send_request(fst_pkg::MODE_REMOVE, k, 4'd8, '1);
      send_request(fst_pkg::MODE_LOOKUP, k, 4'd8, '0);
      send_request(fst_pkg::MODE_UPDATE, k, 4'd8, '1);
      send_request(fst_pkg::MODE_REMOVE, k, 4'd8, '0);
   endtask

   task automatic test_key_extremes();
      // empty key with junk in every byte, then found again with a clean key
      send_request(fst_pkg::MODE_INSERT, '1, 4'd0, 64'haaaa_5555_aaaa_5555);
      send_request(fst_pkg::MODE_LOOKUP, '0, 4'd0, '0);
      // overlong length behaves as a full-width key
      send_request(fst_pkg::MODE_INSERT, '1, 4'd15, 64'h1);
      send_request(fst_pkg::MODE_LOOKUP, '1, 4'd8, '0);
      send_request(fst_pkg::MODE_UPDATE, '1, 4'd9, 64'h8000_0000_0000_0000);
      send_request(fst_pkg::MODE_LOOKUP, '1, 4'd15, '0);
      // same first byte but a different length is a different key
      send_request(fst_pkg::MODE_INSERT, 64'hffff_ffff_ffff_ff00, 4'd1, 64'h2);
      send_request(fst_pkg::MODE_LOOKUP, 64'h00, 4'd2, '0);
      send_request(fst_pkg::MODE_REMOVE, 64'h1200, 4'd1, '0);
      send_request(fst_pkg::MODE_REMOVE, '0, 4'd0, '0);
      send_request(fst_pkg::MODE_REMOVE, '1, 4'd8, '0);
   endtask

   task automatic test_full_node();
      logic [63:0] fill_key [fst_pkg::ENTRIES];
      int          victim;
      for (int i = 0; i < fst_pkg::ENTRIES; i++) begin
         fill_key[i] = {$urandom(), 32'(i)};
         send_request(fst_pkg::MODE_INSERT, fill_key[i], 4'd8, rand64());
      end
      send_request(fst_pkg::MODE_INSERT, 64'hdead_beef_0000_0000, 4'd8, rand64());
      // a duplicate still reports present when the node is full
      send_request(fst_pkg::MODE_INSERT, fill_key[fst_pkg::ENTRIES - 1], 4'd8, rand64());
      send_request(fst_pkg::MODE_LOOKUP, fill_key[fst_pkg::ENTRIES - 1], 4'd8, '0);
      victim = $urandom_range(1, fst_pkg::ENTRIES - 2);
      send_request(fst_pkg::MODE_REMOVE, fill_key[victim], 4'd8, '0);
      // lowest free slot is the one just freed
      fill_key[victim] = 64'hdead_beef_0000_0001;
      send_request(fst_pkg::MODE_INSERT, fill_key[victim], 4'd8, rand64());
      for (int i = 0; i < fst_pkg::ENTRIES; i++)
         send_request(fst_pkg::MODE_REMOVE, fill_key[i], 4'd8, '0);
   endtask

   task automatic test_random_traffic(int n_items);
      logic [63:0]       pool_key [96];
      logic [3:0]        pool_len [96];
      int                pick;
      int                roll;
      int                insert_pct;
      fst_pkg::mode_type mode;
      logic [3:0]        len;
      logic [63:0]       key;
      for (int i = 0; i < 96; i++) begin
         pool_key[i] = rand64();
         roll = $urandom_range(0, 9);
         pool_len[i] = (roll < 6) ? 4'd8 :
                       (roll < 9) ? 4'($urandom_range(0, 7)) : 4'($urandom_range(9, 15));
      end
      for (int n = 0; n < n_items; n++) begin
         if (n % 100 == 0) begin
            idle_on = ((n / 100) % 3) != 2;
            // growing and shrinking phases so the node moves between empty and full
            insert_pct = ((n / 100) % 2 == 0) ? 60 : 15;
         end
         if (n == 450) wait_for_results();
         if ($urandom_range(0, 9) == 0) begin
            mode = fst_pkg::mode_type'($urandom_range(0, 3));
            len = 4'($urandom_range(0, 15));
            key = rand64();
         end else begin
            pick = $urandom_range(0, 95);
            roll = $urandom_range(0, 99);
            if (roll < insert_pct) mode = fst_pkg::MODE_INSERT;
            else if (roll < insert_pct + (100 - insert_pct) / 3) mode = fst_pkg::MODE_REMOVE;
            else if ($urandom_range(0, 1) == 1) mode = fst_pkg::MODE_UPDATE;
            else mode = fst_pkg::MODE_LOOKUP;
            len = pool_len[pick];
            key = $urandom_range(0, 1) ? add_stray(pool_key[pick], len) : pool_key[pick];
            if (len < 8) key = $urandom_range(0, 1) ? key :
                                 key & ((64'd1 << (8 * len)) - 64'd1);
         end
         send_request(mode, key, len, rand64());
      end
      idle_on = 1'b1;
   endtask

   initial begin
      int waited;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_basic_ops();
      wait_for_results();
      test_key_extremes();
      wait_for_results();
      test_full_node();
      test_random_traffic(850);
      @(negedge clock);
      req_tvalid <= 1'b0;
      waited = 0;
      while (pending_results.size() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      repeat (200) @(posedge clock);
      if (pending_results.size() != 0) begin
         $error("%0d result items never arrived", pending_results.size());
         failures++;
      end
      if (failures == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
